FILE: src/scanline_cycle_irq_counter_unit_assert.svh
`ifndef SCANLINE_CYCLE_IRQ_COUNTER_UNIT_ASSERT_SVH
`define SCANLINE_CYCLE_IRQ_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCIRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scirq assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SCIRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scirq assertion failed");

`endif

FILE: src/scirq_pkg.sv
package scirq_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_LATCH    = 3'd1,
    OP_LATCH_LO = 3'd2,
    OP_LATCH_HI = 3'd3,
    OP_CONTROL  = 3'd4,
    OP_ACK      = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic run_last;
  } dp_stat_t;

  localparam logic [7:0] COUNT_MAX        = 8'hFF;
  localparam logic [7:0] CTRL_AFTER_ACK   = 8'h01;
  localparam logic [7:0] CTRL_ENABLE      = 8'h02;
  localparam logic [7:0] CTRL_CYCLE_MODE  = 8'h04;
  localparam logic [7:0] NIBBLE_LO_MASK   = 8'h0F;
  localparam logic [7:0] NIBBLE_HI_MASK   = 8'hF0;
  localparam logic [1:0] PHASE_LAST       = 2'd2;

  function automatic logic [6:0] compare_point(input logic [1:0] phase);
    logic [6:0] cp;
    case (phase)
      2'd0:    cp = 7'd113;
      2'd1:    cp = 7'd113;
      default: cp = 7'd112;
    endcase
    return cp;
  endfunction

endpackage

FILE: src/scirq_if.sv
interface scirq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] write_value;
  logic [7:0] tick_cycles;

  modport source (output valid, output operation, output write_value, output tick_cycles,
                  input ready);
  modport sink (input valid, input operation, input write_value, input tick_cycles,
                output ready);
endinterface

interface scirq_out_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [7:0] count_value;

  modport source (output valid, output irq_line, output count_value, input ready);
  modport sink (input valid, input irq_line, input count_value, output ready);
endinterface

interface scirq_cfg_if;
  logic valid;
  logic ready;
  logic ack_restores_enable;

  modport source (output valid, output ack_restores_enable, input ready);
  modport sink (input valid, input ack_restores_enable, output ready);
endinterface

FILE: src/scirq_ctrl.sv
`include "scanline_cycle_irq_counter_unit_assert.svh"

module scirq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  scirq_pkg::dp_stat_t stat,
  output scirq_pkg::dp_cmd_t  cmd
);

  scirq_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;
  logic              out_free;

  assign in_ready  = (state_r == scirq_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      scirq_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = stat.tick_go ? scirq_pkg::ST_RUN : scirq_pkg::ST_DONE;
        end
      end
      scirq_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.run_last) begin
          state_nxt = scirq_pkg::ST_DONE;
        end
      end
      scirq_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = scirq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scirq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scirq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SCIRQ_ASSERT_NEXT(a_accept_leaves_idle, in_fire, !in_ready)
  `SCIRQ_ASSERT_NEXT(a_run_ends, (state_r == scirq_pkg::ST_RUN) && stat.run_last,
                     state_r == scirq_pkg::ST_DONE)
  `SCIRQ_ASSERT_NEXT(a_publish_shows, (state_r == scirq_pkg::ST_DONE) && out_free,
                     out_valid_r && (state_r == scirq_pkg::ST_IDLE))

endmodule

FILE: src/scirq_dp.sv
module scirq_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_operation,
  input  logic [7:0]          in_write_value,
  input  logic [7:0]          in_tick_cycles,
  input  logic                cfg_write,
  input  logic                cfg_ack_restores_enable,
  input  scirq_pkg::dp_cmd_t  cmd,
  output scirq_pkg::dp_stat_t stat,
  output logic                out_irq_line,
  output logic [7:0]          out_count_value
);

  logic       ack_restores_r, ack_restores_nxt;
  logic [6:0] presc_r, presc_nxt;
  logic [7:0] counter_r, counter_nxt;
  logic [7:0] latch_r, latch_nxt;
  logic       after_ack_r, after_ack_nxt;
  logic       enable_r, enable_nxt;
  logic       cycle_mode_r, cycle_mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       irq_r, irq_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic       out_irq_r;
  logic [7:0] out_count_r;
  logic       clock_cnt;

  assign stat.tick_go  = (scirq_pkg::op_t'(in_operation) == scirq_pkg::OP_TICK) && enable_r
                         && (in_tick_cycles != 8'd0);
  assign stat.run_last = (remain_r == 8'd1);

  always_comb begin
    ack_restores_nxt = cfg_write ? cfg_ack_restores_enable : ack_restores_r;
    presc_nxt        = presc_r;
    counter_nxt      = counter_r;
    latch_nxt        = latch_r;
    after_ack_nxt    = after_ack_r;
    enable_nxt       = enable_r;
    cycle_mode_nxt   = cycle_mode_r;
    phase_nxt        = phase_r;
    irq_nxt          = irq_r;
    remain_nxt       = remain_r;
    clock_cnt        = 1'b0;

    if (cmd.load) begin
      remain_nxt = in_tick_cycles;
      case (scirq_pkg::op_t'(in_operation))
        scirq_pkg::OP_LATCH: begin
          latch_nxt = in_write_value;
        end
        scirq_pkg::OP_LATCH_LO: begin
          latch_nxt = (latch_r & scirq_pkg::NIBBLE_HI_MASK)
                      | (in_write_value & scirq_pkg::NIBBLE_LO_MASK);
        end
        scirq_pkg::OP_LATCH_HI: begin
          latch_nxt = (latch_r & scirq_pkg::NIBBLE_LO_MASK)
                      | {in_write_value[3:0], 4'd0};
        end
        scirq_pkg::OP_CONTROL: begin
          after_ack_nxt  = (in_write_value & scirq_pkg::CTRL_AFTER_ACK) != 8'd0;
          enable_nxt     = (in_write_value & scirq_pkg::CTRL_ENABLE) != 8'd0;
          cycle_mode_nxt = (in_write_value & scirq_pkg::CTRL_CYCLE_MODE) != 8'd0;
          if (enable_nxt) begin
            counter_nxt = latch_r;
            presc_nxt   = 7'd0;
            phase_nxt   = 2'd0;
          end
          irq_nxt = 1'b0;
        end
        scirq_pkg::OP_ACK: begin
          if (ack_restores_r) begin
            enable_nxt = after_ack_r;
          end
          irq_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.step) begin
      remain_nxt = remain_r - 8'd1;
      if (cycle_mode_r) begin
        clock_cnt = 1'b1;
      end else if (presc_r >= scirq_pkg::compare_point(phase_r)) begin
        clock_cnt = 1'b1;
        phase_nxt = (phase_r >= scirq_pkg::PHASE_LAST) ? 2'd0 : phase_r + 2'd1;
        presc_nxt = 7'd0;
      end else begin
        presc_nxt = presc_r + 7'd1;
      end
      if (clock_cnt) begin
        if (counter_r == scirq_pkg::COUNT_MAX) begin
          irq_nxt     = 1'b1;
          counter_nxt = latch_r;
        end else begin
          counter_nxt = counter_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_restores_r <= 1'b0;
      presc_r        <= 7'd0;
      counter_r      <= 8'd0;
      latch_r        <= 8'd0;
      after_ack_r    <= 1'b0;
      enable_r       <= 1'b0;
      cycle_mode_r   <= 1'b0;
      phase_r        <= 2'd0;
      irq_r          <= 1'b0;
    end else begin
      ack_restores_r <= ack_restores_nxt;
      presc_r        <= presc_nxt;
      counter_r      <= counter_nxt;
      latch_r        <= latch_nxt;
      after_ack_r    <= after_ack_nxt;
      enable_r       <= enable_nxt;
      cycle_mode_r   <= cycle_mode_nxt;
      phase_r        <= phase_nxt;
      irq_r          <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    if (cmd.publish) begin
      out_irq_r   <= irq_r;
      out_count_r <= counter_r;
    end
  end

  assign out_irq_line    = out_irq_r;
  assign out_count_value = out_count_r;

endmodule

FILE: src/scanline_cycle_irq_counter_unit.sv
// Interrupt timer with an 8-bit up-counter that reloads from its latch and raises the
// line when it passes 0xFF; each input word yields exactly one result word carrying the
// line level and the counter. A latch, control or acknowledge word, or a tick word that
// does not count, goes from IDLE to DONE and from there into the output register once
// that register is free. A tick word with counting enabled and a nonzero cycle count
// passes through RUN between IDLE and DONE until its tick_cycles count runs out, since the
// datapath steps the prescaler and counter by one CPU cycle per clock. The next word is
// accepted as soon as the previous result is in the output register, even while it
// waits there; a second finished result waits inside the block, and the input stalls,
// until the output register is taken. The configuration register can be written at any
// time the block is idle.
module scanline_cycle_irq_counter_unit (
  input  logic clk,
  input  logic rst_n,
  scirq_in_if.sink    in_ch,
  scirq_out_if.source out_ch,
  scirq_cfg_if.sink   cfg_ch
);

  scirq_pkg::dp_cmd_t  cmd;
  scirq_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  scirq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scirq_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_operation            (in_ch.operation),
    .in_write_value          (in_ch.write_value),
    .in_tick_cycles          (in_ch.tick_cycles),
    .cfg_write               (cfg_ch.valid),
    .cfg_ack_restores_enable (cfg_ch.ack_restores_enable),
    .cmd                     (cmd),
    .stat                    (stat),
    .out_irq_line            (out_ch.irq_line),
    .out_count_value         (out_ch.count_value)
  );

endmodule
